/* src/fdre_pkg.sv */
package fdre_pkg;

    // record kinds on the result stream
    localparam logic [1:0] REC_DATA  = 2'd0;
    localparam logic [1:0] REC_CLOSE = 2'd1;
    localparam logic [1:0] REC_DONE  = 2'd2;

    // input item kinds
    localparam logic KIND_PRIME   = 1'b0;
    localparam logic KIND_COMPARE = 1'b1;

    // field widths
    localparam int WORD_W   = 32;
    localparam int OFFSET_W = 18;
    localparam int COUNT_W  = 19;
    localparam int FWORDS_W = 17;

    // byte accounting per run
    localparam logic [3:0] HEADER_BYTES = 4'd8;
    localparam logic [3:0] WORD_BYTES   = 4'd4;

    // result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    // register map, word index into the apb space
    localparam logic REG_FRAME_WORDS = 1'b0;

    typedef struct packed {
        logic                last;
        logic [COUNT_W-1:0]  count;
        logic [WORD_W-1:0]   data;
        logic [OFFSET_W-1:0] offset;
        logic                first;
        logic [1:0]          kind;
    } rec_t;

endpackage

/* src/frame_delta_run_encoder.sv */
// Frame delta run encoder. Words of a frame arrive one per transfer on the input stream
// (tuser 0 primes the reference word, 1 compares against it) and leave as run records
// on the output stream. The reference frame sits in a single-port-read, single-port-write
// synchronous memory of MAX_FRAME_WORDS words: stage one reads the word at the current
// position, stage two compares, writes back changed and primed words and emits records
// into a four-entry queue, with the written word forwarded when the next item hits the
// same entry (frames of one word). Throughput is one item per clock while each item
// yields at most one record and the output takes one record per clock; an item at the
// frame end yields up to three records, and the input then waits for queue room. The
// reference memory is not cleared: comparing a word never primed since reset gives an
// undefined result. frame_words (offset 0x0) may only be changed while idle.
module frame_delta_run_encoder
    import fdre_pkg::*;
#(
    parameter int MAX_FRAME_WORDS = 65536
)
(
    input  logic        clk,
    input  logic        rst_n,
    // apb register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] new_word
    input  logic [0:0]  s_axis_tuser,   // [0] kind
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // [17:0] run_offset, [49:18] data_word,
                                        // [68:50] byte_count, [71:69] zero
    output logic [2:0]  m_axis_tuser,   // [1:0] record_kind, [2] first_of_run
    output logic        m_axis_tlast
);

    localparam int ADDR_W = $clog2(MAX_FRAME_WORDS);
    localparam int CMP_W  = (ADDR_W + 1 > OFFSET_W) ? ADDR_W + 1 : OFFSET_W;

    function automatic logic [COUNT_W-1:0] sat_add(input logic [COUNT_W-1:0] a,
                                                   input logic [3:0] b);
        logic [COUNT_W:0] s;
        s = {1'b0, a} + (COUNT_W + 1)'(b);
        return s[COUNT_W] ? {COUNT_W{1'b1}} : s[COUNT_W-1:0];
    endfunction

    // configuration
    logic [FWORDS_W-1:0] frame_words_reg;
    logic                cfg_write;

    // position and stage one
    logic [ADDR_W-1:0]   pos_reg;
    logic [ADDR_W-1:0]   pos_next;
    logic [CMP_W-1:0]    frame_len;
    logic [CMP_W-1:0]    pos_ext;
    logic                beyond;
    logic [ADDR_W-1:0]   cur_pos;
    logic                cur_eof;
    logic                accept;

    // stage two
    logic                s1_valid_reg;
    logic                s1_kind_reg;
    logic [WORD_W-1:0]   s1_word_reg;
    logic [ADDR_W-1:0]   s1_addr_reg;
    logic                s1_eof_reg;
    logic                s1_clr_reg;
    logic                fwd_reg;
    logic [WORD_W-1:0]   fwd_data_reg;
    logic                s1_fire;

    // reference memory
    logic [WORD_W-1:0]   ref_mem [MAX_FRAME_WORDS];
    logic [WORD_W-1:0]   rdata_reg;
    logic                mem_we;

    // run state
    logic                run_open_reg;
    logic                run_open_next;
    logic [OFFSET_W-1:0] run_offset_reg;
    logic [OFFSET_W-1:0] run_offset_next;
    logic [COUNT_W-1:0]  run_bytes_reg;
    logic [COUNT_W-1:0]  run_bytes_next;
    logic [COUNT_W-1:0]  total_reg;
    logic [COUNT_W-1:0]  total_next;

    // records towards the queue
    rec_t [2:0]          push_rec;
    logic [1:0]          push_n;
    logic                room;
    rec_t                out_rec;

    // register port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_FRAME_WORDS);
    assign prdata    = (paddr[2] == REG_FRAME_WORDS) ? 32'(frame_words_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_words_reg <= '1 & FWORDS_W'(0) | {1'b1, {(FWORDS_W-1){1'b0}}};
        end
        else if (cfg_write)
        begin
            frame_words_reg <= pwdata[FWORDS_W-1:0];
        end
    end

    // effective frame length and position of the incoming item
    always_comb
    begin
        if (frame_words_reg == '0)
        begin
            frame_len = CMP_W'(1);
        end
        else if (CMP_W'(frame_words_reg) > CMP_W'(MAX_FRAME_WORDS))
        begin
            frame_len = CMP_W'(MAX_FRAME_WORDS);
        end
        else
        begin
            frame_len = CMP_W'(frame_words_reg);
        end
        pos_ext  = CMP_W'(pos_reg);
        beyond   = (pos_ext >= frame_len);
        cur_pos  = beyond ? '0 : pos_reg;
        cur_eof  = (CMP_W'(cur_pos) + CMP_W'(1)) >= frame_len;
        pos_next = cur_eof ? '0 : cur_pos + ADDR_W'(1);
    end

    assign s1_fire       = s1_valid_reg && ((s1_kind_reg == KIND_PRIME) || room);
    assign s_axis_tready = !s1_valid_reg || s1_fire;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            s1_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                pos_reg <= pos_next;
                fwd_reg <= s1_fire && mem_we && (s1_addr_reg == cur_pos);
            end
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
                fwd_reg      <= 1'b0;
            end
        end
    end

    // stage two payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_kind_reg  <= s_axis_tuser[0];
            s1_word_reg  <= s_axis_tdata;
            s1_addr_reg  <= cur_pos;
            s1_eof_reg   <= cur_eof;
            s1_clr_reg   <= beyond;
            fwd_data_reg <= s1_word_reg;
        end
    end

    // reference memory, read on accept, written back from stage two
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ref_mem[s1_addr_reg] <= s1_word_reg;
        end
        if (accept)
        begin
            rdata_reg <= ref_mem[cur_pos];
        end
    end

    // compare, run tracking and record build
    always_comb
    begin
        logic [WORD_W-1:0]   ref_word;
        logic                differ;
        logic                ro;
        logic [COUNT_W-1:0]  rb;
        logic [COUNT_W-1:0]  tot;
        logic [OFFSET_W-1:0] off;
        logic [CMP_W-1:0]    addr_ext;
        logic                has_a;
        logic                has_b;
        logic                has_c;
        rec_t                rec_a;
        rec_t                rec_b;
        rec_t                rec_c;

        ref_word = fwd_reg ? fwd_data_reg : rdata_reg;
        differ   = (ref_word != s1_word_reg);
        addr_ext = CMP_W'(s1_addr_reg);
        ro       = s1_clr_reg ? 1'b0 : run_open_reg;
        off      = s1_clr_reg ? '0 : run_offset_reg;
        rb       = s1_clr_reg ? '0 : run_bytes_reg;
        tot      = s1_clr_reg ? '0 : total_reg;
        has_a    = 1'b0;
        has_b    = 1'b0;
        has_c    = 1'b0;
        rec_a    = '0;
        rec_b    = '0;
        rec_c    = '0;

        // run data word or run close
        if (differ)
        begin
            rec_a.first = !ro;
            if (!ro)
            begin
                off = {addr_ext[OFFSET_W-3:0], 2'b00};
                rb  = '0;
                tot = sat_add(tot, HEADER_BYTES);
            end
            ro          = 1'b1;
            rb          = sat_add(rb, WORD_BYTES);
            tot         = sat_add(tot, WORD_BYTES);
            has_a       = 1'b1;
            rec_a.kind  = REC_DATA;
            rec_a.offset = off;
            rec_a.data  = s1_word_reg;
        end
        else if (ro)
        begin
            has_a        = 1'b1;
            rec_a.kind   = REC_CLOSE;
            rec_a.offset = off;
            rec_a.count  = rb;
            ro           = 1'b0;
            rb           = '0;
        end

        // frame end closes the open run and reports the total
        if (s1_eof_reg)
        begin
            has_b        = ro;
            rec_b.kind   = REC_CLOSE;
            rec_b.offset = off;
            rec_b.count  = rb;
            has_c        = 1'b1;
            rec_c.kind   = REC_DONE;
            rec_c.count  = tot;
            rec_c.last   = 1'b1;
            ro           = 1'b0;
            off          = '0;
            rb           = '0;
            tot          = '0;
        end
        rec_a.last = !has_c;

        // prime drops the run state
        if (s1_kind_reg == KIND_PRIME)
        begin
            has_a = 1'b0;
            has_b = 1'b0;
            has_c = 1'b0;
            ro    = 1'b0;
            off   = '0;
            rb    = '0;
            tot   = '0;
        end

        run_open_next   = ro;
        run_offset_next = off;
        run_bytes_next  = rb;
        total_next      = tot;

        mem_we = s1_fire && ((s1_kind_reg == KIND_PRIME) || differ);

        // pack present records without gaps
        push_rec[0] = has_a ? rec_a : (has_b ? rec_b : rec_c);
        push_rec[1] = (has_a && has_b) ? rec_b : rec_c;
        push_rec[2] = rec_c;
        push_n      = s1_fire ? (2'(has_a) + 2'(has_b) + 2'(has_c)) : 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_open_reg   <= 1'b0;
            run_offset_reg <= '0;
            run_bytes_reg  <= '0;
            total_reg      <= '0;
        end
        else if (s1_fire)
        begin
            run_open_reg   <= run_open_next;
            run_offset_reg <= run_offset_next;
            run_bytes_reg  <= run_bytes_next;
            total_reg      <= total_next;
        end
    end

    // record queue and output stream
    fdre_rec_fifo u_rec_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push_n   (push_n),
        .push_rec (push_rec),
        .room     (room),
        .m_valid  (m_axis_tvalid),
        .m_ready  (m_axis_tready),
        .m_rec    (out_rec)
    );

    assign m_axis_tdata = {3'b000, out_rec.count, out_rec.data, out_rec.offset};
    assign m_axis_tuser = {out_rec.first, out_rec.kind};
    assign m_axis_tlast = out_rec.last;

    a_fwd_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_reg |-> s1_valid_reg)
        else $error("forwarded word without an item in the compare stage");

    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("transfer did not reach the compare stage");

    a_frame_end_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_eof_reg) |=> (!run_open_reg && total_reg == '0))
        else $error("run state left open after frame end");

endmodule

/* src/fdre_rec_fifo.sv */
module fdre_rec_fifo
    import fdre_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [1:0]       push_n,
    input  rec_t [2:0]       push_rec,
    output logic             room,
    output logic             m_valid,
    input  logic             m_ready,
    output rec_t             m_rec
);

    rec_t                  fifo_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic [FIFO_CNT_W-1:0] count_next;
    logic                  pop;

    // output side reads straight from the stored entry
    assign m_valid = (count_reg != '0);
    assign m_rec   = fifo_reg[rd_ptr_reg];
    assign pop     = m_valid && m_ready;

    // space for the largest burst of one item
    assign room = (count_reg <= FIFO_CNT_W'(FIFO_DEPTH - 3));

    // pointer and level bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + FIFO_PTR_W'(push_n);
        rd_ptr_next = rd_ptr_reg + FIFO_PTR_W'(pop);
        count_next  = count_reg + FIFO_CNT_W'(push_n) - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // up to three records land in consecutive slots
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (2'(i) < push_n)
            begin
                fifo_reg[wr_ptr_reg + FIFO_PTR_W'(i)] <= push_rec[i];
            end
        end
    end

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("record queue level beyond its depth");

    a_push_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (push_n != 2'd0) |-> room)
        else $error("records pushed without room for a full burst");

endmodule

/* verif/tb.sv */
`timescale 1ns / 100ps

module tb
    import fdre_pkg::*;
();

    localparam int MAX_WORDS   = 65536;
    localparam int CYCLE_LIMIT = 1_000_000;

    typedef struct {
        logic        kind;
        logic [31:0] word;
    } frame_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;    // [31:0] new_word
    logic [0:0]  s_axis_tuser = '0;    // [0] kind
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;         // [17:0] run_offset, [49:18] data_word,
                                       // [68:50] byte_count, [71:69] zero
    logic [2:0]  m_axis_tuser;         // [1:0] record_kind, [2] first_of_run
    logic        m_axis_tlast;

    // words waiting to be sent and records still owed by the block
    frame_item_t word_queue[$];
    frame_item_t next_item;
    rec_t        pending_records[$];

    int send_idle_pct = 13;
    int recv_idle_pct = 70;
    int error_count   = 0;
    int cycle_count   = 0;
    int items_queued  = 0;

    // encoder state as the block should hold it
    logic [16:0] enc_frame_words = 17'h10000;
    int          enc_pos = 0;
    logic        enc_run_open = 1'b0;
    logic [17:0] enc_run_offset = '0;
    logic [18:0] enc_run_bytes = '0;
    logic [18:0] enc_total = '0;
    logic [31:0] enc_ref [MAX_WORDS];

    // stimulus-side view of the frame, to know which words match
    int          gen_len = MAX_WORDS;
    int          gen_pos = 0;
    logic [31:0] gen_ref [MAX_WORDS];
    bit          gen_written [MAX_WORDS];

    frame_delta_run_encoder #(
        .MAX_FRAME_WORDS (MAX_WORDS)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("frame_delta_run_encoder regression: fail");
            $finish;
        end
    end

    function automatic int frame_len(logic [16:0] value);
        if (value == 0)
            return 1;
        if (value > MAX_WORDS)
            return MAX_WORDS;
        return int'(value);
    endfunction

    function automatic logic [18:0] add_sat(logic [18:0] a, logic [3:0] b);
        logic [19:0] s;
        s = a + b;
        return s[19] ? '1 : s[18:0];
    endfunction

    function automatic void clear_runs();
        enc_run_open   = 1'b0;
        enc_run_offset = '0;
        enc_run_bytes  = '0;
        enc_total      = '0;
    endfunction

    // records caused by one accepted word
    function automatic void encode_word(logic kind, logic [31:0] word);
        int   len;
        int   p;
        rec_t r;
        rec_t recs[$];
        len = frame_len(enc_frame_words);
        if (enc_pos >= len)
        begin
            enc_pos = 0;
            clear_runs();
        end
        p = enc_pos;

        // priming drops any open run silently
        if (kind == KIND_PRIME)
        begin
            enc_ref[p] = word;
            clear_runs();
            enc_pos = (p + 1 >= len) ? 0 : p + 1;
            return;
        end

        if (enc_ref[p] != word)
        begin
            r = '0;
            r.kind  = REC_DATA;
            r.first = !enc_run_open;
            if (!enc_run_open)
            begin
                enc_run_open   = 1'b1;
                enc_run_offset = 18'(p * 4);
                enc_run_bytes  = '0;
                enc_total      = add_sat(enc_total, HEADER_BYTES);
            end
            enc_ref[p]    = word;
            enc_run_bytes = add_sat(enc_run_bytes, WORD_BYTES);
            enc_total     = add_sat(enc_total, WORD_BYTES);
            r.offset = enc_run_offset;
            r.data   = word;
            recs.push_back(r);
        end
        else if (enc_run_open)
        begin
            r = '0;
            r.kind   = REC_CLOSE;
            r.offset = enc_run_offset;
            r.count  = enc_run_bytes;
            recs.push_back(r);
            enc_run_open  = 1'b0;
            enc_run_bytes = '0;
        end

        // frame end: close what is open, then report the total
        if (p + 1 >= len)
        begin
            if (enc_run_open)
            begin
                r = '0;
                r.kind   = REC_CLOSE;
                r.offset = enc_run_offset;
                r.count  = enc_run_bytes;
                recs.push_back(r);
            end
            r = '0;
            r.kind  = REC_DONE;
            r.count = enc_total;
            recs.push_back(r);
            enc_pos = 0;
            clear_runs();
        end
        else
        begin
            enc_pos = p + 1;
        end

        if (recs.size() != 0)
            recs[recs.size() - 1].last = 1'b1;
        foreach (recs[i])
            pending_records.push_back(recs[i]);
    endfunction

    function automatic void report_error(string msg);
        if (error_count < 10)
            $display("%s", msg);
        error_count++;
    endfunction

    // input stream driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                encode_word(s_axis_tuser[0], s_axis_tdata);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (word_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    next_item = word_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= next_item.word;
                    s_axis_tuser  <= next_item.kind;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // output stream monitor and checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                check_record();
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    function automatic void check_record();
        rec_t got;
        rec_t exp_rec;
        got.kind   = m_axis_tuser[1:0];
        got.first  = m_axis_tuser[2];
        got.offset = m_axis_tdata[17:0];
        got.data   = m_axis_tdata[49:18];
        got.count  = m_axis_tdata[68:50];
        got.last   = m_axis_tlast;
        if (pending_records.size() == 0)
        begin
            report_error($sformatf("unexpected record kind %0d offset %0d data %h count %0d",
                got.kind, got.offset, got.data, got.count));
            return;
        end
        exp_rec = pending_records.pop_front();
        if (got != exp_rec)
            report_error($sformatf({"record mismatch at cycle %0d: expected kind %0d ",
                "first %0d offset %0d data %h count %0d last %0d, got kind %0d first %0d ",
                "offset %0d data %h count %0d last %0d"}, cycle_count,
                exp_rec.kind, exp_rec.first, exp_rec.offset, exp_rec.data, exp_rec.count,
                exp_rec.last, got.kind, got.first, got.offset, got.data, got.count, got.last));
    endfunction

    // stimulus bookkeeping: every transfer leaves its word in the reference
    function automatic int upcoming_pos();
        return (gen_pos >= gen_len) ? 0 : gen_pos;
    endfunction

    function automatic void queue_item(logic kind, logic [31:0] word);
        frame_item_t it;
        int          p;
        p = upcoming_pos();
        if (kind == KIND_PRIME)
            gen_written[p] = 1'b1;
        gen_ref[p] = word;
        gen_pos = (p + 1 >= gen_len) ? 0 : p + 1;
        it.kind = kind;
        it.word = word;
        word_queue.push_back(it);
        items_queued++;
    endfunction

    function automatic logic [31:0] changed_word(logic [31:0] w);
        logic [31:0] v;
        case ($urandom_range(0, 2))
            0:       v = w ^ (32'h1 << $urandom_range(0, 31));
            1:       v = ~w;
            default: v = $urandom;
        endcase
        if (v == w)
            v = ~w;
        return v;
    endfunction

    // compare against a known word; an unprimed slot is primed instead
    function automatic void queue_compare(bit differ);
        int p;
        p = upcoming_pos();
        if (!gen_written[p])
            queue_item(KIND_PRIME, $urandom);
        else
            queue_item(KIND_COMPARE, differ ? changed_word(gen_ref[p]) : gen_ref[p]);
    endfunction

    task automatic wait_idle();
        @(negedge clk);
        while (word_queue.size() != 0 || s_axis_tvalid || pending_records.size() != 0)
            @(negedge clk);
        // a final prime may still be in the pipeline
        repeat (10) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_frame_words(logic [16:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_FRAME_WORDS, 2'b00};
        pwdata  <= {15'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        enc_frame_words = value;
        gen_len = frame_len(value);
        @(negedge clk);
    endtask

    // small frames: prime, then compare passes with random differences
    task automatic random_phase(int n);
        int target;
        int len;
        int count;
        bit all_primed;
        logic [16:0] value;
        target = items_queued + n;
        while (items_queued < target)
        begin
            wait_idle();
            value = ($urandom_range(0, 19) == 0) ? 17'd0 : 17'($urandom_range(1, 12));
            write_frame_words(value);
            len = gen_len;
            all_primed = 1'b1;
            for (int i = 0; i < len; i++)
                if (!gen_written[i])
                    all_primed = 1'b0;
            if (!all_primed || $urandom_range(0, 2) == 0)
                for (int i = 0; i < len; i++)
                    queue_item(KIND_PRIME, $urandom);
            // odd counts leave the position mid-frame for the next length change
            count = len * $urandom_range(1, 4) + $urandom_range(0, len - 1);
            for (int i = 0; i < count; i++)
            begin
                if ($urandom_range(0, 99) < 6)
                    queue_item(KIND_PRIME, $urandom);
                else
                    queue_compare($urandom_range(0, 99) < 45);
            end
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // oversized length acts as the largest frame
        write_frame_words(17'h1FFFF);
        queue_item(KIND_PRIME, 32'h0000_0000);
        queue_item(KIND_PRIME, 32'hFFFF_FFFF);
        queue_item(KIND_PRIME, $urandom);
        wait_idle();
        // position now lies beyond the shorter frame
        write_frame_words(17'd3);
        queue_item(KIND_COMPARE, 32'hFFFF_FFFF);
        queue_item(KIND_COMPARE, 32'h0000_0000);
        queue_compare(1'b0);
        // run reaching the frame end: data, close and done from one word
        queue_compare(1'b0);
        queue_compare(1'b1);
        queue_compare(1'b1);
        queue_compare(1'b1);
        queue_compare(1'b0);
        queue_compare(1'b0);
        // prime in the middle of an open run
        queue_compare(1'b1);
        queue_item(KIND_PRIME, $urandom);
        queue_compare(1'b1);
        wait_idle();
        // zero length acts as one word
        write_frame_words(17'd0);
        queue_item(KIND_PRIME, $urandom);
        queue_compare(1'b0);
        queue_compare(1'b1);
        queue_compare(1'b0);

        random_phase(105);
        wait_idle();
        send_idle_pct = 70;
        recv_idle_pct = 13;
        random_phase(105);
        wait_idle();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(100);

        wait_idle();
        if (pending_records.size() != 0)
            report_error($sformatf("%0d records never arrived", pending_records.size()));
        if (error_count == 0)
            $display("frame_delta_run_encoder regression: pass");
        else
            $display("frame_delta_run_encoder regression: fail");
        $finish;
    end

endmodule
